@@ hw/rtl/ttr_pkg.sv @@
// ----------------------------------------------------------------------------
// ttr_pkg
// shared types and constants of the tile triangle rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package ttr_pkg;

    localparam int COORD_W = 16;
    localparam int Z_W     = 16;
    localparam int PIX_W   = 12;
    localparam int FRAME_W = 13;
    localparam int AREA_W  = 36;
    localparam int WGT_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic CMD_TILE = 1'b0;
    localparam logic CMD_TRI  = 1'b1;

    localparam logic [1:0] CULL_NEG = 2'd1;
    localparam logic [1:0] CULL_POS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CULL    = 2'd2;

    typedef struct packed {
        logic                     is_tri;
        logic [PIX_W-1:0]         org_x;
        logic [PIX_W-1:0]         org_y;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic [Z_W-1:0]           z0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [Z_W-1:0]           z1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [Z_W-1:0]           z2;
        logic signed [AREA_W-1:0] area;
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/tile_triangle_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// tile_triangle_rasterizer_top
// edge function tile rasterizer with local depth test
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready takes one command per beat: start tile (sets
// origin, clears the tile depth store) or triangle (three 12.4 vertices)
// output channel o_valid/i_ready gives one fragment per beat, o_last on the
// final fragment of a triangle; a triangle with no fragment gives no beat
// setup: the front steps a triangle through its multiply, subtract and cull
// states and takes a start tile command straight to its push; it runs ahead
// of the walker by up to three commands, two of them queued
// walker: one tile pixel at a time; a clipped pixel skips the edge test, a
// pixel outside the triangle skips division and depth, and a covered one
// uses the shared edge/depth multiplier and the 17-step weight divider
// one fragment is held back until the next is known, so o_last is exact
// reset: depth store reads as farthest (valid bits cleared), origin zero,
// frame 640x480, no culling; no clearing pass is needed
// a stalled receiver stops the walker at its next fragment; the front and
// queue keep accepting until the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module tile_triangle_rasterizer_top #(
    parameter int TILE_SIZE = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [1:0]          i_cfg_idx,
    input  wire  [12:0]         i_cfg_data,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_command,
    input  wire  [8:0]          i_tile_col,
    input  wire  [8:0]          i_tile_row,
    input  wire  signed [15:0]  i_v0_x,
    input  wire  signed [15:0]  i_v0_y,
    input  wire  [15:0]         i_v0_z,
    input  wire  signed [15:0]  i_v1_x,
    input  wire  signed [15:0]  i_v1_y,
    input  wire  [15:0]         i_v1_z,
    input  wire  signed [15:0]  i_v2_x,
    input  wire  signed [15:0]  i_v2_y,
    input  wire  [15:0]         i_v2_z,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [11:0]         o_pixel_x,
    output logic [11:0]         o_pixel_y,
    output logic [15:0]         o_depth,
    output logic [16:0]         o_weight0,
    output logic [16:0]         o_weight1,
    output logic [16:0]         o_weight2,
    output logic                o_last
);

    logic [12:0]    r_frame_w;
    logic [12:0]    r_frame_h;
    logic [1:0]     r_cull;

    logic           f_valid;
    logic           f_ready;
    ttr_pkg::t_cmd  f_cmd;
    logic           q_valid;
    logic           q_ready;
    ttr_pkg::t_cmd  q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= 13'd640;
            r_frame_h <= 13'd480;
            r_cull    <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ttr_pkg::REG_FRAME_W: r_frame_w <= i_cfg_data;
                ttr_pkg::REG_FRAME_H: r_frame_h <= i_cfg_data;
                ttr_pkg::REG_CULL:    r_cull    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    ttr_front #(.TILE_SIZE(TILE_SIZE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cull_mode (r_cull),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_tile_col  (i_tile_col),
        .i_tile_row  (i_tile_row),
        .i_v0_x      (i_v0_x),
        .i_v0_y      (i_v0_y),
        .i_v0_z      (i_v0_z),
        .i_v1_x      (i_v1_x),
        .i_v1_y      (i_v1_y),
        .i_v1_z      (i_v1_z),
        .i_v2_x      (i_v2_x),
        .i_v2_y      (i_v2_y),
        .i_v2_z      (i_v2_z),
        .o_q_valid   (f_valid),
        .i_q_ready   (f_ready),
        .o_q_cmd     (f_cmd)
    );

    ttr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    ttr_back #(.TILE_SIZE(TILE_SIZE)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_w),
        .i_frame_height (r_frame_h),
        .i_q_valid      (q_valid),
        .o_q_ready      (q_ready),
        .i_q_cmd        (q_cmd),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_depth        (o_depth),
        .o_weight0      (o_weight0),
        .o_weight1      (o_weight1),
        .o_weight2      (o_weight2),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

@@ hw/rtl/ttr_front.sv @@
// ----------------------------------------------------------------------------
// ttr_front
// accepts commands, computes doubled triangle area, culls and queues work
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_front #(
    parameter int TILE_SIZE = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [1:0]                   i_cull_mode,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_command,
    input  wire  [8:0]                   i_tile_col,
    input  wire  [8:0]                   i_tile_row,
    input  wire  signed [15:0]           i_v0_x,
    input  wire  signed [15:0]           i_v0_y,
    input  wire  [15:0]                  i_v0_z,
    input  wire  signed [15:0]           i_v1_x,
    input  wire  signed [15:0]           i_v1_y,
    input  wire  [15:0]                  i_v1_z,
    input  wire  signed [15:0]           i_v2_x,
    input  wire  signed [15:0]           i_v2_y,
    input  wire  [15:0]                  i_v2_z,
    output logic                         o_q_valid,
    input  wire                          i_q_ready,
    output ttr_pkg::t_cmd                o_q_cmd
);

    typedef enum logic [2:0] {F_IDLE, F_M0, F_M1, F_SUB, F_DEC, F_PUSH} t_fstate;

    t_fstate                         r_state;
    ttr_pkg::t_cmd                   r_cmd;
    logic signed [33:0]              r_prod;
    logic signed [16:0]              m_a;
    logic signed [16:0]              m_b;
    logic signed [33:0]              m_p;
    logic [12:0]                     org_x_full;
    logic [12:0]                     org_y_full;
    logic                            drop;

    assign org_x_full = 13'(i_tile_col) * 13'(TILE_SIZE);
    assign org_y_full = 13'(i_tile_row) * 13'(TILE_SIZE);

    always_comb begin
        if (r_state == F_M0) begin
            m_a = 17'(r_cmd.x2) - 17'(r_cmd.x0);
            m_b = 17'(r_cmd.y1) - 17'(r_cmd.y0);
        end else begin
            m_a = 17'(r_cmd.y2) - 17'(r_cmd.y0);
            m_b = 17'(r_cmd.x1) - 17'(r_cmd.x0);
        end
        m_p = m_a * m_b;
    end

    always_comb begin
        drop = (r_cmd.area == '0)
            || (i_cull_mode == ttr_pkg::CULL_NEG && r_cmd.area < 0)
            || (i_cull_mode == ttr_pkg::CULL_POS && r_cmd.area > 0);
    end

    assign o_ready   = (r_state == F_IDLE);
    assign o_q_valid = (r_state == F_PUSH);
    assign o_q_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_cmd.is_tri <= i_command;
                        r_cmd.org_x  <= org_x_full[11:0];
                        r_cmd.org_y  <= org_y_full[11:0];
                        r_cmd.x0 <= i_v0_x; r_cmd.y0 <= i_v0_y; r_cmd.z0 <= i_v0_z;
                        r_cmd.x1 <= i_v1_x; r_cmd.y1 <= i_v1_y; r_cmd.z1 <= i_v1_z;
                        r_cmd.x2 <= i_v2_x; r_cmd.y2 <= i_v2_y; r_cmd.z2 <= i_v2_z;
                        r_state <= (i_command == ttr_pkg::CMD_TRI) ? F_M0 : F_PUSH;
                    end
                end
                F_M0: begin
                    r_prod  <= m_p;
                    r_state <= F_M1;
                end
                F_M1: begin
                    r_cmd.area <= ttr_pkg::AREA_W'(r_prod);
                    r_prod     <= m_p;
                    r_state    <= F_SUB;
                end
                F_SUB: begin
                    r_cmd.area <= r_cmd.area - ttr_pkg::AREA_W'(r_prod);
                    r_state    <= F_DEC;
                end
                F_DEC: begin
                    r_state <= drop ? F_IDLE : F_PUSH;
                end
                F_PUSH: begin
                    if (i_q_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ttr_queue.sv @@
// ----------------------------------------------------------------------------
// ttr_queue
// two-entry command queue between setup and pixel walker
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  ttr_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  wire                i_ready,
    output ttr_pkg::t_cmd      o_cmd
);

    ttr_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ttr_back.sv @@
// ----------------------------------------------------------------------------
// ttr_back
// walks tile pixels: edge test, weight division, depth interpolation and test
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_back #(
    parameter int TILE_SIZE = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [12:0]          i_frame_width,
    input  wire  [12:0]          i_frame_height,
    input  wire                  i_q_valid,
    output logic                 o_q_ready,
    input  ttr_pkg::t_cmd        i_q_cmd,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [11:0]          o_pixel_x,
    output logic [11:0]          o_pixel_y,
    output logic [15:0]          o_depth,
    output logic [16:0]          o_weight0,
    output logic [16:0]          o_weight1,
    output logic [16:0]          o_weight2,
    output logic                 o_last
);

    localparam int NSLOT  = TILE_SIZE * TILE_SIZE;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int IDX_W  = $clog2(TILE_SIZE);
    localparam int AW     = ttr_pkg::AREA_W;

    typedef enum logic [3:0] {
        B_IDLE, B_PIX, B_EDGE, B_TEST, B_DIV, B_Z, B_CMP, B_EMIT, B_NEXT, B_FLUSH
    } t_bstate;

    t_bstate               r_state;
    ttr_pkg::t_cmd         r_tri;
    logic [11:0]           r_org_x;
    logic [11:0]           r_org_y;
    logic [AW-1:0]         r_amag;
    logic                  r_aneg;
    logic [IDX_W-1:0]      r_i;
    logic [IDX_W-1:0]      r_j;
    logic [SLOT_W-1:0]     r_slot;
    logic [11:0]           r_px;
    logic [11:0]           r_py;
    logic [2:0]            r_k;
    logic [3:0]            r_dk;
    logic signed [34:0]    r_prod;
    logic signed [AW-1:0]  r_f0;
    logic signed [AW-1:0]  r_f1;
    logic signed [AW-1:0]  r_f2;
    logic [AW-1:0]         r_rem0;
    logic [AW-1:0]         r_rem1;
    logic [16:0]           r_q0;
    logic [16:0]           r_q1;
    logic [33:0]           r_zacc;
    logic [15:0]           r_rd_data;
    logic                  r_rd_vld;
    logic [NSLOT-1:0]      r_dvld;
    logic [15:0]           r_mem [NSLOT];
    logic [15:0]           r_new_z;
    logic                  r_pend_vld;
    logic [11:0]           r_pend_x;
    logic [11:0]           r_pend_y;
    logic [15:0]           r_pend_z;
    logic [16:0]           r_pend_w0;
    logic [16:0]           r_pend_w1;
    logic                  r_out_vld;

    logic [12:0]           px_full;
    logic [12:0]           py_full;
    logic                  clipped;
    logic signed [17:0]    cx;
    logic signed [17:0]    cy;
    logic signed [17:0]    m_a;
    logic signed [16:0]    m_b;
    logic signed [34:0]    m_p;
    logic [2:0]            km1;
    logic [AW-1:0]         mag0;
    logic [AW-1:0]         mag1;
    logic                  pass;
    logic [AW:0]           sh0;
    logic [AW:0]           sh1;
    logic [16:0]           w2;
    logic [16:0]           pend_w2;
    logic [31:0]           z_round;
    logic [15:0]           stored_z;
    logic                  out_free;
    logic                  out_load;
    logic                  last_pix;
    logic                  mem_we;

    assign px_full = {1'b0, r_org_x} + 13'(r_i);
    assign py_full = {1'b0, r_org_y} + 13'(r_j);
    assign clipped = (px_full >= i_frame_width) || px_full[12]
                  || (py_full >= i_frame_height) || py_full[12];
    assign cx      = {2'b00, r_px, 4'b1000};
    assign cy      = {2'b00, r_py, 4'b1000};
    assign km1     = r_k - 3'd1;

    always_comb begin
        m_a = '0;
        m_b = '0;
        if (r_state == B_EDGE) begin
            case (r_k)
                3'd0: begin m_a = cx - 18'(r_tri.x1); m_b = 17'(r_tri.y2) - 17'(r_tri.y1); end
                3'd1: begin m_a = cy - 18'(r_tri.y1); m_b = 17'(r_tri.x2) - 17'(r_tri.x1); end
                3'd2: begin m_a = cx - 18'(r_tri.x2); m_b = 17'(r_tri.y0) - 17'(r_tri.y2); end
                3'd3: begin m_a = cy - 18'(r_tri.y2); m_b = 17'(r_tri.x0) - 17'(r_tri.x2); end
                3'd4: begin m_a = cx - 18'(r_tri.x0); m_b = 17'(r_tri.y1) - 17'(r_tri.y0); end
                default: begin
                    m_a = cy - 18'(r_tri.y0);
                    m_b = 17'(r_tri.x1) - 17'(r_tri.x0);
                end
            endcase
        end else begin
            case (r_k)
                3'd0:    begin m_a = {1'b0, r_q0}; m_b = {1'b0, r_tri.z0}; end
                3'd1:    begin m_a = {1'b0, r_q1}; m_b = {1'b0, r_tri.z1}; end
                default: begin m_a = {1'b0, w2};   m_b = {1'b0, r_tri.z2}; end
            endcase
        end
        m_p = m_a * m_b;
    end

    assign mag0 = r_f0[AW-1] ? AW'(-r_f0) : AW'(r_f0);
    assign mag1 = r_f1[AW-1] ? AW'(-r_f1) : AW'(r_f1);
    assign pass = (r_f0 == '0 || r_f0[AW-1] == r_aneg)
               && (r_f1 == '0 || r_f1[AW-1] == r_aneg)
               && (r_f2 == '0 || r_f2[AW-1] == r_aneg);
    assign sh0  = {r_rem0, 1'b0};
    assign sh1  = {r_rem1, 1'b0};
    assign w2      = 17'(18'd65536 - 18'(r_q0) - 18'(r_q1));
    assign pend_w2 = 17'(18'd65536 - 18'(r_pend_w0) - 18'(r_pend_w1));
    assign z_round  = r_zacc[31:0] + 32'd32768;
    assign stored_z = r_rd_vld ? r_rd_data : 16'hFFFF;
    assign out_free = !r_out_vld || i_ready;
    assign out_load = r_pend_vld && out_free
                   && ((r_state == B_EMIT) || (r_state == B_FLUSH));
    assign last_pix = (r_i == IDX_W'(TILE_SIZE - 1)) && (r_j == IDX_W'(TILE_SIZE - 1));
    assign mem_we   = (r_state == B_CMP) && (z_round[31:16] < stored_z);

    assign o_q_ready = (r_state == B_IDLE);
    assign o_valid   = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= z_round[31:16];
        end
        if (r_state == B_TEST) begin
            r_rd_data <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_dvld     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_out_vld && i_ready && !out_load) begin
                r_out_vld <= 1'b0;
            end
            if (mem_we) begin
                r_dvld[r_slot] <= 1'b1;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_cmd.is_tri == ttr_pkg::CMD_TILE) begin
                            r_org_x <= i_q_cmd.org_x;
                            r_org_y <= i_q_cmd.org_y;
                            r_dvld  <= '0;
                        end else begin
                            r_tri   <= i_q_cmd;
                            r_aneg  <= i_q_cmd.area[AW-1];
                            r_amag  <= i_q_cmd.area[AW-1] ? AW'(-i_q_cmd.area)
                                                           : AW'(i_q_cmd.area);
                            r_i     <= '0;
                            r_j     <= '0;
                            r_slot  <= '0;
                            r_state <= B_PIX;
                        end
                    end
                end
                B_PIX: begin
                    r_px <= px_full[11:0];
                    r_py <= py_full[11:0];
                    r_k  <= '0;
                    r_state <= clipped ? B_NEXT : B_EDGE;
                end
                B_EDGE: begin
                    r_prod <= m_p;
                    if (r_k != 3'd0) begin
                        case (km1)
                            3'd0: r_f0 <= AW'(r_prod);
                            3'd1: r_f0 <= r_f0 - AW'(r_prod);
                            3'd2: r_f1 <= AW'(r_prod);
                            3'd3: r_f1 <= r_f1 - AW'(r_prod);
                            3'd4: r_f2 <= AW'(r_prod);
                            default: r_f2 <= r_f2 - AW'(r_prod);
                        endcase
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd6) begin
                        r_state <= B_TEST;
                    end
                end
                B_TEST: begin
                    r_rd_vld <= r_dvld[r_slot];
                    if (mag0 >= r_amag) begin
                        r_rem0 <= mag0 - r_amag;
                        r_q0   <= 17'd1;
                    end else begin
                        r_rem0 <= mag0;
                        r_q0   <= 17'd0;
                    end
                    if (mag1 >= r_amag) begin
                        r_rem1 <= mag1 - r_amag;
                        r_q1   <= 17'd1;
                    end else begin
                        r_rem1 <= mag1;
                        r_q1   <= 17'd0;
                    end
                    r_dk    <= '0;
                    r_state <= pass ? B_DIV : B_NEXT;
                end
                B_DIV: begin
                    if (sh0 >= {1'b0, r_amag}) begin
                        r_rem0 <= AW'(sh0 - {1'b0, r_amag});
                        r_q0   <= {r_q0[15:0], 1'b1};
                    end else begin
                        r_rem0 <= AW'(sh0);
                        r_q0   <= {r_q0[15:0], 1'b0};
                    end
                    if (sh1 >= {1'b0, r_amag}) begin
                        r_rem1 <= AW'(sh1 - {1'b0, r_amag});
                        r_q1   <= {r_q1[15:0], 1'b1};
                    end else begin
                        r_rem1 <= AW'(sh1);
                        r_q1   <= {r_q1[15:0], 1'b0};
                    end
                    r_dk <= r_dk + 4'd1;
                    if (r_dk == 4'd15) begin
                        r_k     <= '0;
                        r_zacc  <= '0;
                        r_state <= B_Z;
                    end
                end
                B_Z: begin
                    r_prod <= m_p;
                    if (r_k != 3'd0) begin
                        r_zacc <= r_zacc + 34'(r_prod);
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd3) begin
                        r_state <= B_CMP;
                    end
                end
                B_CMP: begin
                    r_new_z <= z_round[31:16];
                    r_state <= mem_we ? B_EMIT : B_NEXT;
                end
                B_EMIT: begin
                    if (!r_pend_vld || out_free) begin
                        if (r_pend_vld) begin
                            r_out_vld <= 1'b1;
                            o_pixel_x <= r_pend_x;
                            o_pixel_y <= r_pend_y;
                            o_depth   <= r_pend_z;
                            o_weight0 <= r_pend_w0;
                            o_weight1 <= r_pend_w1;
                            o_weight2 <= pend_w2;
                            o_last    <= 1'b0;
                        end
                        r_pend_vld <= 1'b1;
                        r_pend_x   <= r_px;
                        r_pend_y   <= r_py;
                        r_pend_z   <= r_new_z;
                        r_pend_w0  <= r_q0;
                        r_pend_w1  <= r_q1;
                        r_state    <= B_NEXT;
                    end
                end
                B_NEXT: begin
                    r_slot <= r_slot + SLOT_W'(1);
                    if (r_i == IDX_W'(TILE_SIZE - 1)) begin
                        r_i <= '0;
                        r_j <= r_j + IDX_W'(1);
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                    r_state <= last_pix ? B_FLUSH : B_PIX;
                end
                B_FLUSH: begin
                    if (!r_pend_vld) begin
                        r_state <= B_IDLE;
                    end else if (out_free) begin
                        r_out_vld  <= 1'b1;
                        o_pixel_x  <= r_pend_x;
                        o_pixel_y  <= r_pend_y;
                        o_depth    <= r_pend_z;
                        o_weight0  <= r_pend_w0;
                        o_weight1  <= r_pend_w1;
                        o_weight2  <= pend_w2;
                        o_last     <= 1'b1;
                        r_pend_vld <= 1'b0;
                        r_state    <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> !r_pend_vld)
        else $error("pending fragment left over between commands");

    a_wsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_Z) |-> ((18'(r_q0) + 18'(r_q1)) <= 18'd65536))
        else $error("barycentric weights exceed one");

    a_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_new_z != 16'hFFFF))
        else $error("farthest depth passed the depth test");

endmodule

`default_nettype wire

@@ test/tile_triangle_rasterizer_top_tb.sv @@
// ----------------------------------------------------------------------------
// tile_triangle_rasterizer_top_tb
// self-checking bench: a software rasterizer with its own depth store predicts
// every fragment; directed corners, a configuration sweep and random tiles and
// triangles run, the sweep and most random traffic under random stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_triangle_rasterizer_top_tb;

    localparam int TS = 8;
    localparam int SETTLE_CYCLES = 9000;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam logic [1:0] CULL_NONE = 2'd0;
    localparam logic [1:0] CULL_ALSO_NONE = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [8:0]        col;
        logic [8:0]        row;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic [15:0]       z0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [15:0]       z1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic [15:0]       z2;
    } t_raster_cmd;

    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
        logic [15:0] z;
        logic [16:0] w0;
        logic [16:0] w1;
        logic [16:0] w2;
        logic        last;
    } t_fragment;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [12:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_command = 1'b0;
    logic [8:0] i_tile_col = '0;
    logic [8:0] i_tile_row = '0;
    logic signed [15:0] i_v0_x = '0, i_v0_y = '0, i_v1_x = '0, i_v1_y = '0;
    logic signed [15:0] i_v2_x = '0, i_v2_y = '0;
    logic [15:0] i_v0_z = '0, i_v1_z = '0, i_v2_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [11:0] o_pixel_x, o_pixel_y;
    logic [15:0] o_depth;
    logic [16:0] o_weight0, o_weight1, o_weight2;
    logic o_last;

    tile_triangle_rasterizer_top #(.TILE_SIZE(TS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_tile_col(i_tile_col), .i_tile_row(i_tile_row),
        .i_v0_x(i_v0_x), .i_v0_y(i_v0_y), .i_v0_z(i_v0_z),
        .i_v1_x(i_v1_x), .i_v1_y(i_v1_y), .i_v1_z(i_v1_z),
        .i_v2_x(i_v2_x), .i_v2_y(i_v2_y), .i_v2_z(i_v2_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y), .o_depth(o_depth),
        .o_weight0(o_weight0), .o_weight1(o_weight1), .o_weight2(o_weight2),
        .o_last(o_last)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [15:0] zbuf [TS*TS];
    logic [11:0] org_x, org_y;
    logic [12:0] frame_w, frame_h;
    logic [1:0]  cull;
    t_fragment   frag_q [$];

    int errors = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy);
        return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit same_side(longint f, longint a);
        return f == 0 || ((f < 0) == (a < 0));
    endfunction

    task automatic rasterize_expected(input t_raster_cmd c);
        longint x0, y0, x1, y1, x2, y2, area, cx, cy, f0, f1, f2, w0, w1, w2, z;
        int px, py, slot;
        t_fragment tri_q [$];
        t_fragment f;
        if (c.cmd == ttr_pkg::CMD_TILE) begin
            org_x = 12'(c.col * TS);
            org_y = 12'(c.row * TS);
            for (int k = 0; k < TS*TS; k++) zbuf[k] = 16'hFFFF;
            return;
        end
        x0 = c.x0; y0 = c.y0; x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2;
        area = edge_val(x0, y0, x1, y1, x2, y2);
        if (cull == ttr_pkg::CULL_NEG && area < 0) return;
        if (cull == ttr_pkg::CULL_POS && area > 0) return;
        if (area == 0) return;
        for (int j = 0; j < TS; j++) begin
            py = int'(org_y) + j;
            if (py >= int'(frame_h) || py > 4095) continue;
            for (int i = 0; i < TS; i++) begin
                px = int'(org_x) + i;
                if (px >= int'(frame_w) || px > 4095) continue;
                cx = longint'(px) * 16 + 8;
                cy = longint'(py) * 16 + 8;
                f0 = edge_val(x1, y1, x2, y2, cx, cy);
                f1 = edge_val(x2, y2, x0, y0, cx, cy);
                f2 = edge_val(x0, y0, x1, y1, cx, cy);
                if (!same_side(f0, area) || !same_side(f1, area) || !same_side(f2, area))
                    continue;
                w0 = (mag(f0) << 16) / mag(area);
                w1 = (mag(f1) << 16) / mag(area);
                w2 = 65536 - w0 - w1;
                z = (w0 * c.z0 + w1 * c.z1 + w2 * c.z2 + 32768) >> 16;
                slot = j * TS + i;
                if (z >= zbuf[slot]) continue;
                zbuf[slot] = 16'(z);
                f.px = 12'(px); f.py = 12'(py); f.z = 16'(z);
                f.w0 = 17'(w0); f.w1 = 17'(w1); f.w2 = 17'(w2); f.last = 1'b0;
                tri_q = {tri_q, f};
            end
        end
        if (tri_q.size() > 0) tri_q[tri_q.size()-1].last = 1'b1;
        foreach (tri_q[k]) frag_q = {frag_q, tri_q[k]};
    endtask

    // returns with the accepted beat still driven; tx_stop or the next call ends it
    task automatic send_cmd(input t_raster_cmd c);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command <= c.cmd; i_tile_col <= c.col; i_tile_row <= c.row;
        i_v0_x <= c.x0; i_v0_y <= c.y0; i_v0_z <= c.z0;
        i_v1_x <= c.x1; i_v1_y <= c.y1; i_v1_z <= c.z1;
        i_v2_x <= c.x2; i_v2_y <= c.y2; i_v2_z <= c.z2;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        rasterize_expected(c);
    endtask

    task automatic tx_stop();
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        tx_stop();
        while (frag_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        drain();
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ttr_pkg::REG_FRAME_W: frame_w = val;
            ttr_pkg::REG_FRAME_H: frame_h = val;
            ttr_pkg::REG_CULL:    cull = val[1:0];
            default: ;
        endcase
    endtask

    function automatic t_raster_cmd tile_cmd(input int col, input int row);
        t_raster_cmd c;
        c = '0;
        c.cmd = ttr_pkg::CMD_TILE; c.col = 9'(col); c.row = 9'(row);
        c.x0 = 16'($urandom); c.y0 = 16'($urandom); c.z0 = 16'($urandom);
        return c;
    endfunction

    function automatic t_raster_cmd tri_cmd(input int ax, input int ay, input int bx,
                                            input int by, input int qx, input int qy,
                                            input int za, input int zb, input int zc);
        t_raster_cmd c;
        c.cmd = ttr_pkg::CMD_TRI; c.col = 9'($urandom); c.row = 9'($urandom);
        c.x0 = 16'(ax); c.y0 = 16'(ay); c.z0 = 16'(za);
        c.x1 = 16'(bx); c.y1 = 16'(by); c.z1 = 16'(zb);
        c.x2 = 16'(qx); c.y2 = 16'(qy); c.z2 = 16'(zc);
        return c;
    endfunction

    // vertices scattered around the current tile, 12.4 units
    function automatic t_raster_cmd near_tri();
        int bx, by;
        bx = int'(org_x) * 16;
        by = int'(org_y) * 16;
        return tri_cmd(bx + $urandom_range(0, 255) - 64, by + $urandom_range(0, 255) - 64,
                       bx + $urandom_range(0, 255) - 64, by + $urandom_range(0, 255) - 64,
                       bx + $urandom_range(0, 255) - 64, by + $urandom_range(0, 255) - 64,
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
    endfunction

    function automatic t_raster_cmd any_cmd();
        t_raster_cmd c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) c = tile_cmd($urandom_range(0, 39), $urandom_range(0, 29));
        else if (r < 15) c = tile_cmd($urandom_range(0, 511), $urandom_range(0, 511));
        else if (r < 90) c = near_tri();
        else c = tri_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        return c;
    endfunction

    task automatic test_directed();
        send_cmd(tile_cmd(0, 0));
        send_cmd(tri_cmd(0, 0, 0, 200, 200, 0, 100, 200, 300));
        send_cmd(tri_cmd(0, 0, 0, 200, 200, 0, 100, 200, 300));
        send_cmd(tri_cmd(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0));
        send_cmd(tri_cmd(0, 0, 128, 0, 0, 128, 0, 65535, 65535));
        send_cmd(tri_cmd(10, 10, 50, 50, 90, 90, 1, 2, 3));
        send_cmd(tile_cmd(1, 1));
        send_cmd(tri_cmd(0, 0, 400, 0, 0, 400, 65535, 65535, 65535));
        send_cmd(tri_cmd(128, 128, 128, 256, 256, 128, 0, 0, 0));
        send_cmd(tile_cmd(511, 511));
        send_cmd(tri_cmd(32767, 32767, -32768, 32767, 32767, -32768, 5, 5, 5));
        send_cmd(tile_cmd(2, 3));
        write_reg(ttr_pkg::REG_CULL, 13'(ttr_pkg::CULL_NEG));
        send_cmd(tri_cmd(32, 48, 32, 200, 200, 48, 10, 20, 30));
        send_cmd(tri_cmd(32, 48, 200, 48, 32, 200, 10, 20, 30));
        write_reg(ttr_pkg::REG_CULL, 13'(ttr_pkg::CULL_POS));
        send_cmd(tile_cmd(2, 3));
        send_cmd(tri_cmd(32, 48, 32, 200, 200, 48, 10, 20, 30));
        send_cmd(tri_cmd(32, 48, 200, 48, 32, 200, 10, 20, 30));
        write_reg(ttr_pkg::REG_CULL, 13'(CULL_ALSO_NONE));
        send_cmd(tile_cmd(2, 3));
        send_cmd(tri_cmd(32, 48, 32, 200, 200, 48, 10, 20, 30));
        write_reg(ttr_pkg::REG_CULL, 13'(CULL_NONE));
    endtask

    task automatic test_backpressure();
        send_cmd(tile_cmd(4, 4));
        hold_req = 3000;
        repeat (15) send_cmd(near_tri());
        drain();
        repeat (5) send_cmd(near_tri());
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) send_cmd(any_cmd());
    endtask

    task automatic test_config_sweep();
        logic [12:0] widths [6] = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd640, 13'd13};
        logic [12:0] heights [6] = '{13'd1, 13'd4096, 13'd8191, 13'd480, 13'd0, 13'd11};
        logic [1:0] culls [6] = '{CULL_NONE, CULL_ALSO_NONE, ttr_pkg::CULL_NEG, CULL_NONE,
                                  ttr_pkg::CULL_POS, ttr_pkg::CULL_NEG};
        for (int k = 0; k < 6; k++) begin
            write_reg(ttr_pkg::REG_FRAME_W, widths[k]);
            write_reg(ttr_pkg::REG_FRAME_H, heights[k]);
            write_reg(ttr_pkg::REG_CULL, 13'(culls[k]));
            send_cmd(tile_cmd($urandom_range(0, 2), $urandom_range(0, 2)));
            test_random_traffic(10);
        end
        write_reg(ttr_pkg::REG_FRAME_W, 13'd640);
        write_reg(ttr_pkg::REG_FRAME_H, 13'd480);
        write_reg(ttr_pkg::REG_CULL, 13'(CULL_NONE));
    endtask

    // fragment checker, receiver stalls and watchdog
    always @(posedge i_clk) begin
        t_fragment e;
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL tile_triangle_rasterizer_top");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (frag_q.size() == 0) begin
                $error("unexpected fragment beat x=%0d y=%0d", o_pixel_x, o_pixel_y);
                errors++;
            end else begin
                e = frag_q.pop_front();
                if (o_pixel_x !== e.px) begin
                    $error("pixel_x exp %0d got %0d", e.px, o_pixel_x); errors++;
                end
                if (o_pixel_y !== e.py) begin
                    $error("pixel_y exp %0d got %0d", e.py, o_pixel_y); errors++;
                end
                if (o_depth !== e.z) begin
                    $error("depth exp %0d got %0d", e.z, o_depth); errors++;
                end
                if (o_weight0 !== e.w0) begin
                    $error("weight0 exp %0d got %0d", e.w0, o_weight0); errors++;
                end
                if (o_weight1 !== e.w1) begin
                    $error("weight1 exp %0d got %0d", e.w1, o_weight1); errors++;
                end
                if (o_weight2 !== e.w2) begin
                    $error("weight2 exp %0d got %0d", e.w2, o_weight2); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); errors++;
                end
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        for (int k = 0; k < TS*TS; k++) zbuf[k] = 16'hFFFF;
        org_x = '0; org_y = '0;
        frame_w = 13'd640; frame_h = 13'd480; cull = CULL_NONE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        tx_idle_pct = 28; rx_idle_pct = 81;
        test_random_traffic(130);
        tx_idle_pct = 81; rx_idle_pct = 28;
        test_random_traffic(130);
        tx_idle_pct = 0; rx_idle_pct = 0;
        test_random_traffic(130);
        tx_idle_pct = 28; rx_idle_pct = 28;
        test_config_sweep();
        drain();
        if (frag_q.size() != 0) begin
            $error("%0d fragments never arrived", frag_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS tile_triangle_rasterizer_top");
        end else begin
            $display("FAIL tile_triangle_rasterizer_top");
        end
        $finish;
    end

endmodule
